[src/sorted_axis_range_query_table_assert.svh]
// Assertion macros for the sorted-axis range query table.
`ifndef SORTED_AXIS_RANGE_QUERY_TABLE_ASSERT_SVH
`define SORTED_AXIS_RANGE_QUERY_TABLE_ASSERT_SVH

// Same-cycle implication, checked on clk and held off while rst_n is low.
`define SARQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sarq check failed");

// Next-cycle implication, checked on clk and held off while rst_n is low.
`define SARQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sarq check failed");

`endif

[src/sarq_pkg.sv]
// Shared constants, codes and types of the sorted-axis range query table.
package sarq_pkg;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 24;
  localparam int ID_BITS    = 16;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_MOVE   = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NOID = 2'd1;
  localparam logic [1:0] STAT_DUP  = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  localparam logic [2:0] CMD_HOLD    = 3'd0;
  localparam logic [2:0] CMD_CLR     = 3'd1;
  localparam logic [2:0] CMD_SCAN_ID = 3'd2;
  localparam logic [2:0] CMD_SCAN_LR = 3'd3;
  localparam logic [2:0] CMD_REMOVE  = 3'd4;
  localparam logic [2:0] CMD_INSERT  = 3'd5;
  localparam logic [2:0] CMD_ROTATE  = 3'd6;

  localparam logic [1:0] MODE_LT   = 2'd0;
  localparam logic [1:0] MODE_LE   = 2'd1;
  localparam logic [1:0] MODE_STAY = 2'd2;

  typedef struct packed {
    logic [ID_BITS-1:0]           id;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } ent_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] mode;
    ent_t       ent;
  } ctl_t;

  typedef struct packed {
    logic               v;
    logic               hit;
    logic               tail;
    logic [ID_BITS-1:0] id;
  } hit_t;

endpackage

[src/sorted_axis_range_query_table.sv]
// Top level of the sorted-axis range query table: cell chain, sequencer and result port.
// Entities sit in a chain of CAPACITY cells kept in ascending x order. Every id lookup
// is a scan that ripples one cell per cycle down the chain before the single result of
// an insert or remove; move runs a lookup, a removal, a second scan for the landing side
// and a placement. A query rotates the chain once through its head cell into the distance
// pipeline; matches come out in table order during the rotation, at most one per cycle.
// busy falls in the cycle in which the last result of an item is on the out_ ports, so
// the next item can be accepted at the edge that takes that result. Each result is on the
// out_ ports for one cycle with out_strobe high and must be taken then; the block has no
// way to hold a result back. No initialization pass is needed after reset.
module sorted_axis_range_query_table (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_operation,
  input  logic [sarq_pkg::ID_BITS-1:0]           in_entity_id,
  input  logic signed [sarq_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [sarq_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic signed [sarq_pkg::COORD_BITS-1:0] in_pos_z,
  input  logic [sarq_pkg::COORD_BITS-2:0]        in_radius,
  output logic                                   out_strobe,
  output logic [1:0]                             out_status,
  output logic                                   out_match_valid,
  output logic [sarq_pkg::ID_BITS-1:0]           out_match_id,
  output logic                                   out_last
);
  import sarq_pkg::*;

  `include "sorted_axis_range_query_table_assert.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN1  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SCAN2  = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_QUERY  = 3'd5;
  localparam logic [2:0] S_DRAIN  = 3'd6;
  localparam logic [2:0] S_FINAL  = 3'd7;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);

  logic [2:0]                state_r, state_nxt;
  logic [IDX_BITS-1:0]       cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0]       count_r, count_nxt;
  logic [1:0]                op_r;
  ent_t                      item_r;
  logic [COORD_BITS-2:0]     rad_r;
  logic [2*COORD_BITS-3:0]   rsq_r;
  logic                      pend_v_r, pend_v_nxt;
  logic [ID_BITS-1:0]        pend_id_r, pend_id_nxt;

  logic                      accept;
  ctl_t                      ctl;
  hit_t                      hit;
  ent_t                      ents [CAPACITY];
  logic [CAPACITY-1:0]       used_v, keep_v, p_v, ql_v, qr_v;
  logic                      found, full, tail_in;

  logic                      emit;
  logic [1:0]                e_status;
  logic                      e_mv, e_last;
  logic [ID_BITS-1:0]        e_id;
  logic                      strobe_r;
  logic [1:0]                status_r;
  logic                      mv_r, last_r;
  logic [ID_BITS-1:0]        mid_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign found  = p_v[CAPACITY-1];
  assign full   = (count_r == CNT_BITS'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ent_t pe, ne;
    logic pu, pk, nu, pi, li, ri;
    if (i == 0) begin : g_first
      assign pe = ctl.ent;
      assign pu = 1'b0;
      assign pk = 1'b1;
      assign pi = 1'b0;
      assign li = 1'b0;
      assign ri = 1'b0;
    end else begin : g_rest
      assign pe = ents[i-1];
      assign pu = used_v[i-1];
      assign pk = keep_v[i-1];
      assign pi = p_v[i-1];
      assign li = ql_v[i-1];
      assign ri = qr_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      // The tail closes the ring for a rotation and takes an empty slot on removal.
      assign ne = ents[0];
      assign nu = (ctl.cmd == CMD_ROTATE) && used_v[0];
    end else begin : g_mid
      assign ne = ents[i+1];
      assign nu = used_v[i+1];
    end
    sarq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_ent  (pe),
      .prev_used (pu),
      .prev_keep (pk),
      .next_ent  (ne),
      .next_used (nu),
      .p_in      (pi),
      .ql_in     (li),
      .qr_in     (ri),
      .ent       (ents[i]),
      .used      (used_v[i]),
      .keep      (keep_v[i]),
      .p_out     (p_v[i]),
      .ql_out    (ql_v[i]),
      .qr_out    (qr_v[i])
    );
  end

  assign tail_in = (state_r == S_QUERY) && (cnt_r == LAST_IDX);

  sarq_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .v     (state_r == S_QUERY),
    .used  (used_v[0]),
    .tail  (tail_in),
    .ent   (ents[0]),
    .ox    (item_r.x),
    .oy    (item_r.y),
    .oz    (item_r.z),
    .r     (rad_r),
    .rsq   (rsq_r),
    .hit   (hit)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    count_nxt   = count_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    ctl.cmd     = CMD_HOLD;
    ctl.mode    = MODE_LT;
    ctl.ent     = item_r;
    emit        = 1'b0;
    e_status    = STAT_OK;
    e_mv        = 1'b0;
    e_id        = '0;
    e_last      = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.cmd    = CMD_CLR;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = (in_operation == OP_QUERY) ? S_QUERY : S_SCAN1;
        end
      end
      S_SCAN1: begin
        ctl.cmd = CMD_SCAN_ID;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        emit      = 1'b1;
        state_nxt = S_IDLE;
        if (op_r == OP_INSERT) begin
          if (found) begin
            e_status = STAT_DUP;
          end else if (full) begin
            e_status = STAT_FULL;
          end else begin
            ctl.cmd   = CMD_INSERT;
            count_nxt = count_r + 1'b1;
          end
        end else if (!found) begin
          e_status = STAT_NOID;
        end else begin
          ctl.cmd   = CMD_REMOVE;
          count_nxt = count_r - 1'b1;
          if (op_r == OP_MOVE) begin
            emit      = 1'b0;
            cnt_nxt   = '0;
            state_nxt = S_SCAN2;
          end
        end
      end
      S_SCAN2: begin
        ctl.cmd = CMD_SCAN_LR;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) state_nxt = S_PLACE;
      end
      S_PLACE: begin
        ctl.cmd   = CMD_INSERT;
        ctl.mode  = ql_v[CAPACITY-1] ? MODE_LE : (qr_v[CAPACITY-1] ? MODE_LT : MODE_STAY);
        count_nxt = count_r + 1'b1;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QUERY, S_DRAIN: begin
        if (state_r == S_QUERY) begin
          ctl.cmd = CMD_ROTATE;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LAST_IDX) state_nxt = S_DRAIN;
        end
        // A match is held back until the next one arrives so the final one can carry last.
        if (hit.v && hit.hit) begin
          if (pend_v_r) begin
            emit   = 1'b1;
            e_mv   = 1'b1;
            e_id   = pend_id_r;
            e_last = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = hit.id;
        end
        if (hit.v && hit.tail) state_nxt = S_FINAL;
      end
      S_FINAL: begin
        emit      = 1'b1;
        e_mv      = pend_v_r;
        e_id      = pend_v_r ? pend_id_r : '0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_operation;
      item_r.id <= in_entity_id;
      item_r.x  <= in_pos_x;
      item_r.y  <= in_pos_y;
      item_r.z  <= in_pos_z;
      rad_r     <= in_radius;
      rsq_r     <= {{(COORD_BITS-1){1'b0}}, in_radius} *
                   {{(COORD_BITS-1){1'b0}}, in_radius};
    end
    cnt_r     <= cnt_nxt;
    pend_id_r <= pend_id_nxt;
    status_r  <= e_status;
    mv_r      <= e_mv;
    mid_r     <= e_id;
    last_r    <= e_last;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      strobe_r <= emit;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_match_valid = mv_r;
  assign out_match_id    = mid_r;
  assign out_last        = last_r;

  `SARQ_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_BITS'(CAPACITY))
  `SARQ_ASSERT_IMP(a_match_ok, out_strobe && out_match_valid, out_status == STAT_OK)
  `SARQ_ASSERT_NXT(a_accept_busy, accept, busy)
  `SARQ_ASSERT_IMP(a_more_follows, out_strobe && !out_last, busy)

endmodule

[src/sarq_cell.sv]
// One table slot: holds an entity and its scan flags, and trades data with its neighbors.
module sarq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  sarq_pkg::ctl_t ctl,
  input  sarq_pkg::ent_t prev_ent,
  input  logic           prev_used,
  input  logic           prev_keep,
  input  sarq_pkg::ent_t next_ent,
  input  logic           next_used,
  input  logic           p_in,
  input  logic           ql_in,
  input  logic           qr_in,
  output sarq_pkg::ent_t ent,
  output logic           used,
  output logic           keep,
  output logic           p_out,
  output logic           ql_out,
  output logic           qr_out
);
  import sarq_pkg::*;

  ent_t ent_r, ent_nxt;
  logic used_r, used_nxt;
  logic p_r, p_nxt, ql_r, ql_nxt, qr_r, qr_nxt;

  always_comb begin
    case (ctl.mode)
      MODE_LT:   keep = used_r && (ent_r.x < ctl.ent.x);
      MODE_LE:   keep = used_r && (ent_r.x <= ctl.ent.x);
      MODE_STAY: keep = used_r && !p_r;
      default:   keep = used_r && (ent_r.x < ctl.ent.x);
    endcase
  end

  always_comb begin
    ent_nxt  = ent_r;
    used_nxt = used_r;
    p_nxt    = p_r;
    ql_nxt   = ql_r;
    qr_nxt   = qr_r;
    case (ctl.cmd)
      CMD_CLR: begin
        p_nxt  = 1'b0;
        ql_nxt = 1'b0;
        qr_nxt = 1'b0;
      end
      CMD_SCAN_ID: p_nxt = p_in | (used_r && (ent_r.id == ctl.ent.id));
      CMD_SCAN_LR: begin
        // Left: an earlier entry lies beyond the new x. Right: a later one lies short of it.
        ql_nxt = ql_in | (used_r && !p_r && (ent_r.x > ctl.ent.x));
        qr_nxt = qr_in | (used_r && p_r && (ent_r.x < ctl.ent.x));
      end
      CMD_REMOVE: begin
        if (p_r) begin
          ent_nxt  = next_ent;
          used_nxt = next_used;
        end
      end
      CMD_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            ent_nxt  = ctl.ent;
            used_nxt = 1'b1;
          end else begin
            ent_nxt  = prev_ent;
            used_nxt = prev_used;
          end
        end
      end
      CMD_ROTATE: begin
        ent_nxt  = next_ent;
        used_nxt = next_used;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      used_r <= 1'b0;
      p_r    <= 1'b0;
      ql_r   <= 1'b0;
      qr_r   <= 1'b0;
    end else begin
      used_r <= used_nxt;
      p_r    <= p_nxt;
      ql_r   <= ql_nxt;
      qr_r   <= qr_nxt;
    end
  end

  assign ent    = ent_r;
  assign used   = used_r;
  assign p_out  = p_r;
  assign ql_out = ql_r;
  assign qr_out = qr_r;

endmodule

[src/sarq_dist.sv]
// Two-stage distance check of the entity leaving the head of the chain.
module sarq_dist (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       v,
  input  logic                                       used,
  input  logic                                       tail,
  input  sarq_pkg::ent_t                             ent,
  input  logic signed [sarq_pkg::COORD_BITS-1:0]     ox,
  input  logic signed [sarq_pkg::COORD_BITS-1:0]     oy,
  input  logic signed [sarq_pkg::COORD_BITS-1:0]     oz,
  input  logic [sarq_pkg::COORD_BITS-2:0]            r,
  input  logic [2*sarq_pkg::COORD_BITS-3:0]          rsq,
  output sarq_pkg::hit_t                             hit
);
  import sarq_pkg::*;

  localparam int CB = COORD_BITS;

  function automatic logic [CB-1:0] absd(logic signed [CB-1:0] a, logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    d = {a[CB-1], a} - {b[CB-1], b};
    absd = d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  logic [CB-1:0]      ax_nxt, ay_nxt, az_nxt;
  logic [CB-1:0]      ax_r, ay_r, az_r;
  logic               v1_r, ok1_r, t1_r;
  logic [ID_BITS-1:0] id1_r;
  logic [2*CB-1:0]    sx_r, sy_r, sz_r;
  logic               v2_r, ok2_r, t2_r;
  logic [ID_BITS-1:0] id2_r;
  logic [2*CB+1:0]    sum;
  logic               far;

  assign ax_nxt = absd(ent.x, ox);
  assign ay_nxt = absd(ent.y, oy);
  assign az_nxt = absd(ent.z, oz);
  assign far = (ax_r > {1'b0, r}) || (ay_r > {1'b0, r}) || (az_r > {1'b0, r});

  always_ff @(posedge clk) begin
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    az_r  <= az_nxt;
    ok1_r <= used;
    t1_r  <= tail;
    id1_r <= ent.id;
    sx_r  <= {{CB{1'b0}}, ax_r} * {{CB{1'b0}}, ax_r};
    sy_r  <= {{CB{1'b0}}, ay_r} * {{CB{1'b0}}, ay_r};
    sz_r  <= {{CB{1'b0}}, az_r} * {{CB{1'b0}}, az_r};
    ok2_r <= ok1_r && !far;
    t2_r  <= t1_r;
    id2_r <= id1_r;
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v;
      v2_r <= v1_r;
    end
  end

  assign sum = {2'b00, sx_r} + {2'b00, sy_r} + {2'b00, sz_r};

  assign hit.v    = v2_r;
  assign hit.hit  = ok2_r && (sum <= {4'b0000, rsq});
  assign hit.tail = t2_r;
  assign hit.id   = id2_r;

endmodule
